### design/ycbcr_to_rgb_pixel_packer_assert.svh
// Assertion macros used by the pixel packer conversion module (yrp_conv).
// Each macro expects signals named clk and rst in the using scope.
`ifndef YCBCR_TO_RGB_PIXEL_PACKER_ASSERT_SVH
`define YCBCR_TO_RGB_PIXEL_PACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define YRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define YRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/yrp_pkg.sv
package yrp_pkg;

  // Output format codes; the unused code behaves as FMT_RGBX.
  localparam logic [1:0] FMT_RGB565 = 2'd0;
  localparam logic [1:0] FMT_RGB888 = 2'd1;
  localparam logic [1:0] FMT_RGBX   = 2'd2;

  // Register select (word index taken from paddr[2]).
  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_GRAY   = 1'b1;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Signed width of the weighted sums (covers -71k..137k).
  localparam int SUM_W = 19;
  localparam int DIFF_W = 9;

  localparam logic [DIFF_W-1:0] LUMA_OFS   = 9'd16;
  localparam logic [DIFF_W-1:0] CHROMA_OFS = 9'd128;

  localparam logic signed [SUM_W-1:0] K_Y     = 19'sd298;
  localparam logic signed [SUM_W-1:0] K_R_CR  = 19'sd409;
  localparam logic signed [SUM_W-1:0] K_G_CB  = 19'sd100;
  localparam logic signed [SUM_W-1:0] K_G_CR  = 19'sd208;
  localparam logic signed [SUM_W-1:0] K_B_CB  = 19'sd516;
  localparam logic signed [SUM_W-1:0] K_ROUND = 19'sd128;

  localparam logic [3:0] BE_TWO   = 4'd3;
  localparam logic [3:0] BE_THREE = 4'd7;
  localparam logic [2:0] ADV_2 = 3'd2;
  localparam logic [2:0] ADV_3 = 3'd3;
  localparam logic [2:0] ADV_4 = 3'd4;

  localparam logic [1:0] FMT_RESET  = FMT_RGBX;
  localparam logic       GRAY_RESET = 1'b0;

  typedef struct packed {
    logic [1:0] output_format;
    logic       gray_mode;
  } cfg_t;

  // Floor-shift by 8 and clamp to 0..255.
  function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] sum);
    logic [7:0] res;
    if (sum[SUM_W-1]) begin
      res = 8'd0;
    end else if (|sum[SUM_W-2:16]) begin
      res = 8'hFF;
    end else begin
      res = sum[15:8];
    end
    return res;
  endfunction

endpackage

### design/ycbcr_to_rgb_pixel_packer.sv
// YCbCr to RGB pixel packer.
// Request channel: drive luma, chroma_blue and chroma_red with start high;
// the request is taken at the rising edge where start is high and busy is
// low. busy is never raised, so one request can be taken every cycle.
// Result channel: done pulses for one cycle with pixel_word, byte_enable
// and byte_advance valid; the receiver must take it in that cycle.
// Path: the accepting edge loads the input register and the next edge
// loads the result register and raises done; the receiver takes the
// result while done is high.
// Throughput: one pixel per clock, set by the single pass of weighting,
// clamp and pack between the two registers.
// Configuration: APB registers at byte 0 (output_format, reset 2 = RGB plus
// pad byte) and byte 4 (gray_mode, reset 0). Write them only while idle.
// Reset (rst, synchronous) drops any request in flight and restores the
// register defaults. Format code 3 behaves as code 2.
module ycbcr_to_rgb_pixel_packer (
  input  logic                       clk,
  input  logic                       rst,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [yrp_pkg::ADDR_W-1:0] paddr,
  input  logic [yrp_pkg::DATA_W-1:0] pwdata,
  output logic [yrp_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // request channel
  input  logic                       start,
  output logic                       busy,
  input  logic [7:0]                 luma,
  input  logic [7:0]                 chroma_blue,
  input  logic [7:0]                 chroma_red,
  // result channel
  output logic                       done,
  output logic [23:0]                pixel_word,
  output logic [3:0]                 byte_enable,
  output logic [2:0]                 byte_advance
);

  yrp_pkg::cfg_t cfg;
  logic          take;

  // The pipeline never stalls: hold busy low.
  assign busy = 1'b0;
  assign take = start & ~busy;

  yrp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  yrp_conv u_conv (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (take),
    .luma         (luma),
    .chroma_blue  (chroma_blue),
    .chroma_red   (chroma_red),
    .done         (done),
    .pixel_word   (pixel_word),
    .byte_enable  (byte_enable),
    .byte_advance (byte_advance)
  );

endmodule

### design/yrp_cfg.sv
module yrp_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [yrp_pkg::ADDR_W-1:0]   paddr,
  input  logic [yrp_pkg::DATA_W-1:0]   pwdata,
  output logic [yrp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output yrp_pkg::cfg_t                cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_format <= yrp_pkg::FMT_RESET;
      cfg.gray_mode     <= yrp_pkg::GRAY_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        yrp_pkg::REG_FORMAT: cfg.output_format <= pwdata[1:0];
        yrp_pkg::REG_GRAY:   cfg.gray_mode     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      yrp_pkg::REG_FORMAT: prdata[1:0] = cfg.output_format;
      yrp_pkg::REG_GRAY:   prdata[0]   = cfg.gray_mode;
      default: ;
    endcase
  end

endmodule

### design/yrp_conv.sv
`include "ycbcr_to_rgb_pixel_packer_assert.svh"

module yrp_conv (
  input  logic          clk,
  input  logic          rst,
  input  yrp_pkg::cfg_t cfg,
  input  logic          start,
  input  logic [7:0]    luma,
  input  logic [7:0]    chroma_blue,
  input  logic [7:0]    chroma_red,
  output logic          done,
  output logic [23:0]   pixel_word,
  output logic [3:0]    byte_enable,
  output logic [2:0]    byte_advance
);

  // Input register
  logic       in_valid;
  logic [7:0] luma_q;
  logic [7:0] cb_q;
  logic [7:0] cr_q;

  logic signed [yrp_pkg::DIFF_W-1:0] c_diff;
  logic signed [yrp_pkg::DIFF_W-1:0] d_diff;
  logic signed [yrp_pkg::DIFF_W-1:0] e_diff;
  logic signed [yrp_pkg::SUM_W-1:0]  c_ext;
  logic signed [yrp_pkg::SUM_W-1:0]  d_ext;
  logic signed [yrp_pkg::SUM_W-1:0]  e_ext;
  logic signed [yrp_pkg::SUM_W-1:0]  y_term;
  logic signed [yrp_pkg::SUM_W-1:0]  r_sum;
  logic signed [yrp_pkg::SUM_W-1:0]  g_sum;
  logic signed [yrp_pkg::SUM_W-1:0]  b_sum;
  logic [7:0]  r_val;
  logic [7:0]  g_val;
  logic [7:0]  b_val;
  logic [23:0] pixel_word_next;
  logic [3:0]  byte_enable_next;
  logic [2:0]  byte_advance_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      luma_q <= luma;
      cb_q   <= chroma_blue;
      cr_q   <= chroma_red;
    end
  end

  always_comb begin
    c_diff = $signed({1'b0, luma_q} - yrp_pkg::LUMA_OFS);
    if (cfg.gray_mode) begin
      d_diff = '0;
      e_diff = '0;
    end else begin
      d_diff = $signed({1'b0, cb_q} - yrp_pkg::CHROMA_OFS);
      e_diff = $signed({1'b0, cr_q} - yrp_pkg::CHROMA_OFS);
    end
    c_ext  = yrp_pkg::SUM_W'(c_diff);
    d_ext  = yrp_pkg::SUM_W'(d_diff);
    e_ext  = yrp_pkg::SUM_W'(e_diff);
    y_term = c_ext * yrp_pkg::K_Y + yrp_pkg::K_ROUND;
    r_sum  = y_term + e_ext * yrp_pkg::K_R_CR;
    g_sum  = y_term - d_ext * yrp_pkg::K_G_CB - e_ext * yrp_pkg::K_G_CR;
    b_sum  = y_term + d_ext * yrp_pkg::K_B_CB;
    r_val  = yrp_pkg::clamp8(r_sum);
    g_val  = yrp_pkg::clamp8(g_sum);
    b_val  = yrp_pkg::clamp8(b_sum);
  end

  always_comb begin
    unique case (cfg.output_format)
      yrp_pkg::FMT_RGB565: begin
        pixel_word_next   = {8'd0, r_val[7:3], g_val[7:2], b_val[7:3]};
        byte_enable_next  = yrp_pkg::BE_TWO;
        byte_advance_next = yrp_pkg::ADV_2;
      end
      yrp_pkg::FMT_RGB888: begin
        pixel_word_next   = {b_val, g_val, r_val};
        byte_enable_next  = yrp_pkg::BE_THREE;
        byte_advance_next = yrp_pkg::ADV_3;
      end
      default: begin
        pixel_word_next   = {b_val, g_val, r_val};
        byte_enable_next  = yrp_pkg::BE_THREE;
        byte_advance_next = yrp_pkg::ADV_4;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      pixel_word   <= pixel_word_next;
      byte_enable  <= byte_enable_next;
      byte_advance <= byte_advance_next;
    end
  end

  `YRP_ASSERT_NEXT(a_start_loads, start, in_valid, "accepted request not loaded")
  `YRP_ASSERT_NEXT(a_stage_done, in_valid, done, "loaded request produced no result")
  `YRP_ASSERT_NOW(a_565_upper, done && byte_enable == yrp_pkg::BE_TWO,
    pixel_word[23:16] == 8'd0, "RGB565 result has upper byte set")
  `YRP_ASSERT_NOW(a_mark_pair, done,
    (byte_enable == yrp_pkg::BE_TWO && byte_advance == yrp_pkg::ADV_2) ||
    (byte_enable == yrp_pkg::BE_THREE &&
     (byte_advance == yrp_pkg::ADV_3 || byte_advance == yrp_pkg::ADV_4)),
    "byte mask and advance disagree")

endmodule

### test/tb_ycbcr_to_rgb_pixel_packer.sv
module tb_ycbcr_to_rgb_pixel_packer;
  timeunit 1ns;
  timeprecision 1ps;

  // Byte addresses of the two registers: word index sits in paddr[2].
  localparam logic [yrp_pkg::ADDR_W-1:0] ADDR_FORMAT = {yrp_pkg::REG_FORMAT, 2'b00};
  localparam logic [yrp_pkg::ADDR_W-1:0] ADDR_GRAY   = {yrp_pkg::REG_GRAY, 2'b00};

  // Share of cycles in which the request side holds start low.
  localparam int GAP_PERCENT = 38;
  // Idle cycles to let pass before touching a register.
  localparam int QUIET_CYCLES = 3;
  // Upper bound on the wait for the last results to drain.
  localparam int DRAIN_CYCLES = 64;
  localparam int PRINT_LIMIT = 40;

  typedef enum logic {REQ_PIXEL, REQ_SETTING} req_kind_t;

  // One entry of the stimulus queue: a pixel request or a register write.
  typedef struct {
    req_kind_t                  kind;
    logic [7:0]                 y;
    logic [7:0]                 cb;
    logic [7:0]                 cr;
    logic                       no_gap;
    logic [yrp_pkg::ADDR_W-1:0] addr;
    logic [yrp_pkg::DATA_W-1:0] data;
  } pend_req_t;

  // Packed pixel as the result channel shows it.
  typedef struct {
    logic [23:0] word;
    logic [3:0]  be;
    logic [2:0]  adv;
  } pix_out_t;

  typedef enum logic [2:0] {
    DRV_STREAM, DRV_QUIET, DRV_WR_SETUP, DRV_WR_ACCESS, DRV_RD_SETUP, DRV_RD_ACCESS
  } drv_state_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [yrp_pkg::ADDR_W-1:0] paddr = '0;
  logic [yrp_pkg::DATA_W-1:0] pwdata = '0;
  logic [yrp_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  logic                       start = 1'b0;
  logic                       busy;
  logic [7:0]                 luma = 8'd0;
  logic [7:0]                 chroma_blue = 8'd0;
  logic [7:0]                 chroma_red = 8'd0;
  logic                       done;
  logic [23:0]                pixel_word;
  logic [3:0]                 byte_enable;
  logic [2:0]                 byte_advance;

  ycbcr_to_rgb_pixel_packer dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .start       (start),
    .busy        (busy),
    .luma        (luma),
    .chroma_blue (chroma_blue),
    .chroma_red  (chroma_red),
    .done        (done),
    .pixel_word  (pixel_word),
    .byte_enable (byte_enable),
    .byte_advance(byte_advance)
  );

  pend_req_t  pend_q[$];
  pix_out_t   rgb_expect_q[$];
  drv_state_t drv_state = DRV_STREAM;
  int         quiet_cnt = 0;

  // Flags recorded at the rising edge for the driver at the next falling edge.
  logic took_req = 1'b0;
  logic apb_done = 1'b0;

  // Shadow of the two registers.
  logic [1:0] cfg_fmt = yrp_pkg::FMT_RESET;
  logic       cfg_gray = yrp_pkg::GRAY_RESET;

  int mismatch_count = 0;
  int pixels_checked = 0;
  int cnt_565 = 0;
  int cnt_888 = 0;
  int cnt_pad = 0;
  int cnt_gray = 0;
  int reg_writes = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Floor-shift by 8, then saturate to one byte.
  function automatic logic [7:0] sat_component(input int sum);
    int q;
    q = sum >>> 8;
    if (sum < 0) begin
      return 8'd0;
    end else if (q > 255) begin
      return 8'hFF;
    end
    return q[7:0];
  endfunction

  // Integer BT.601 conversion followed by packing in the selected format.
  function automatic pix_out_t convert_pixel(input logic [7:0] y, input logic [7:0] cb,
                                             input logic [7:0] cr, input logic [1:0] fmt,
                                             input logic gray);
    int         c;
    int         d;
    int         e;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    pix_out_t   o;
    c = int'(y) - 16;
    d = 0;
    e = 0;
    if (!gray) begin
      d = int'(cb) - 128;
      e = int'(cr) - 128;
    end
    r = sat_component(298 * c + 409 * e + 128);
    g = sat_component(298 * c - 100 * d - 208 * e + 128);
    b = sat_component(298 * c + 516 * d + 128);
    if (fmt == yrp_pkg::FMT_RGB565) begin
      o.word = {8'h00, r[7:3], g[7:2], b[7:3]};
      o.be   = yrp_pkg::BE_TWO;
      o.adv  = yrp_pkg::ADV_2;
    end else begin
      o.word = {b, g, r};
      o.be   = yrp_pkg::BE_THREE;
      o.adv  = (fmt == yrp_pkg::FMT_RGB888) ? yrp_pkg::ADV_3 : yrp_pkg::ADV_4;
    end
    return o;
  endfunction

  task automatic queue_pixel(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr,
                             input logic no_gap);
    pend_req_t r;
    r.kind   = REQ_PIXEL;
    r.y      = y;
    r.cb     = cb;
    r.cr     = cr;
    r.no_gap = no_gap;
    r.addr   = '0;
    r.data   = '0;
    pend_q.push_back(r);
  endtask

  task automatic queue_setting(input logic [yrp_pkg::ADDR_W-1:0] addr,
                               input logic [yrp_pkg::DATA_W-1:0] data);
    pend_req_t r;
    r.kind   = REQ_SETTING;
    r.y      = '0;
    r.cb     = '0;
    r.cr     = '0;
    r.no_gap = 1'b0;
    r.addr   = addr;
    r.data   = data;
    pend_q.push_back(r);
  endtask

  // Mostly uniform bytes, with the range ends and the nominal offsets mixed in.
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 15))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd16;
      3:       return 8'd235;
      4:       return 8'd128;
      5:       return 8'd240;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Request driver: change inputs at the falling edge only. A pixel request
  // holds until the rising edge takes it; a register write waits for the
  // pipeline to drain, then runs a write and a read-back on the APB port.
  always @(negedge clk) begin
    pend_req_t                  head;
    logic                       n_start;
    logic [7:0]                 n_y;
    logic [7:0]                 n_cb;
    logic [7:0]                 n_cr;
    logic                       n_psel;
    logic                       n_penable;
    logic                       n_pwrite;
    logic [yrp_pkg::ADDR_W-1:0] n_addr;
    logic [yrp_pkg::DATA_W-1:0] n_wdata;
    drv_state_t                 n_state;
    int                         n_quiet;
    n_start   = start;
    n_y       = luma;
    n_cb      = chroma_blue;
    n_cr      = chroma_red;
    n_psel    = psel;
    n_penable = penable;
    n_pwrite  = pwrite;
    n_addr    = paddr;
    n_wdata   = pwdata;
    n_state   = drv_state;
    n_quiet   = quiet_cnt;
    if (!rst) begin
      case (drv_state)
        DRV_STREAM: begin
          // Hold a request that was not taken yet.
          if (!(start && !took_req)) begin
            n_start = 1'b0;
            if (pend_q.size() != 0) begin
              head = pend_q[0];
              if (head.kind == REQ_SETTING) begin
                n_state = DRV_QUIET;
                n_quiet = 0;
              end else if (head.no_gap || $urandom_range(0, 99) >= GAP_PERCENT) begin
                n_start = 1'b1;
                n_y     = head.y;
                n_cb    = head.cb;
                n_cr    = head.cr;
                void'(pend_q.pop_front());
              end
            end
          end
        end
        DRV_QUIET: begin
          // Let the last results come out before writing a register.
          if (rgb_expect_q.size() != 0) begin
            n_quiet = 0;
          end else if (quiet_cnt < QUIET_CYCLES) begin
            n_quiet = quiet_cnt + 1;
          end else begin
            head      = pend_q[0];
            n_psel    = 1'b1;
            n_penable = 1'b0;
            n_pwrite  = 1'b1;
            n_addr    = head.addr;
            n_wdata   = head.data;
            n_state   = DRV_WR_SETUP;
          end
        end
        DRV_WR_SETUP: begin
          n_penable = 1'b1;
          n_state   = DRV_WR_ACCESS;
        end
        DRV_WR_ACCESS: begin
          // Follow the write with a read of the same register.
          if (apb_done) begin
            n_penable = 1'b0;
            n_pwrite  = 1'b0;
            n_state   = DRV_RD_SETUP;
          end
        end
        DRV_RD_SETUP: begin
          n_penable = 1'b1;
          n_state   = DRV_RD_ACCESS;
        end
        DRV_RD_ACCESS: begin
          if (apb_done) begin
            n_psel    = 1'b0;
            n_penable = 1'b0;
            void'(pend_q.pop_front());
            n_state   = DRV_STREAM;
          end
        end
        default: n_state = DRV_STREAM;
      endcase
    end
    start       <= n_start;
    luma        <= n_y;
    chroma_blue <= n_cb;
    chroma_red  <= n_cr;
    psel        <= n_psel;
    penable     <= n_penable;
    pwrite      <= n_pwrite;
    paddr       <= n_addr;
    pwdata      <= n_wdata;
    drv_state   <= n_state;
    quiet_cnt   <= n_quiet;
  end

  // Rising-edge monitor: predict each taken request, track register writes,
  // check read-backs, and compare every done pulse with the oldest prediction.
  always @(posedge clk) begin
    pix_out_t                   want;
    logic [yrp_pkg::DATA_W-1:0] rd_want;
    if (rst) begin
      took_req <= 1'b0;
      apb_done <= 1'b0;
      cfg_fmt  <= yrp_pkg::FMT_RESET;
      cfg_gray <= yrp_pkg::GRAY_RESET;
    end else begin
      took_req <= start && !busy;
      apb_done <= psel && penable && pready;

      if (start && !busy) begin
        rgb_expect_q.push_back(convert_pixel(luma, chroma_blue, chroma_red, cfg_fmt, cfg_gray));
        if (cfg_fmt == yrp_pkg::FMT_RGB565) begin
          cnt_565++;
        end else if (cfg_fmt == yrp_pkg::FMT_RGB888) begin
          cnt_888++;
        end else begin
          cnt_pad++;
        end
        if (cfg_gray) begin
          cnt_gray++;
        end
      end

      if (psel && penable && pready) begin
        if (pwrite) begin
          reg_writes++;
          if (paddr[2] == yrp_pkg::REG_FORMAT) begin
            cfg_fmt <= pwdata[1:0];
          end else begin
            cfg_gray <= pwdata[0];
          end
        end else begin
          rd_want = (paddr[2] == yrp_pkg::REG_GRAY) ? yrp_pkg::DATA_W'(cfg_gray)
                                                    : yrp_pkg::DATA_W'(cfg_fmt);
          if (prdata !== rd_want) begin
            report_mismatch($sformatf("read of address %0d: got %08h want %08h",
                                      paddr, prdata, rd_want));
          end
        end
      end

      if (done) begin
        if (rgb_expect_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: word %06h be %0h adv %0d",
                                    pixel_word, byte_enable, byte_advance));
        end else begin
          want = rgb_expect_q.pop_front();
          if (pixel_word !== want.word) begin
            report_mismatch($sformatf("pixel %0d: pixel_word got %06h want %06h",
                                      pixels_checked, pixel_word, want.word));
          end
          if (byte_enable !== want.be) begin
            report_mismatch($sformatf("pixel %0d: byte_enable got %0h want %0h",
                                      pixels_checked, byte_enable, want.be));
          end
          if (byte_advance !== want.adv) begin
            report_mismatch($sformatf("pixel %0d: byte_advance got %0d want %0d",
                                      pixels_checked, byte_advance, want.adv));
          end
          pixels_checked++;
        end
      end
    end
  end

  initial begin
    int n;
    logic [1:0] fmt;
    logic gray;
    logic steady;

    // Directed part, first under the reset setting (padded format, color):
    // black, white, the nominal black and white levels, strong chroma ends.
    queue_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd16,  8'd128, 8'd128, 1'b0);
    queue_pixel(8'd235, 8'd128, 8'd128, 1'b0);
    queue_pixel(8'd255, 8'd0,   8'd255, 1'b0);
    queue_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    // RGB565 packing, with saturated and mid-range components.
    queue_setting(ADDR_FORMAT, yrp_pkg::DATA_W'(yrp_pkg::FMT_RGB565));
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    queue_pixel(8'd128, 8'd255, 8'd0,   1'b0);
    queue_pixel(8'd81,  8'd90,  8'd240, 1'b0);
    queue_pixel(8'd210, 8'd16,  8'd146, 1'b0);
    queue_pixel(8'd145, 8'd54,  8'd34,  1'b0);
    // Three-byte format.
    queue_setting(ADDR_FORMAT, yrp_pkg::DATA_W'(yrp_pkg::FMT_RGB888));
    queue_pixel(8'd0,   8'd255, 8'd255, 1'b0);
    queue_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    queue_pixel(8'd41,  8'd240, 8'd110, 1'b0);
    queue_pixel(8'd170, 8'd166, 8'd16,  1'b0);
    queue_pixel(8'd106, 8'd202, 8'd222, 1'b0);
    // Unused format code must act as the padded format.
    queue_setting(ADDR_FORMAT, 32'd3);
    queue_pixel(8'd235, 8'd128, 8'd128, 1'b0);
    queue_pixel(8'd16,  8'd240, 8'd16,  1'b0);
    queue_pixel(8'd200, 8'd60,  8'd200, 1'b0);
    // Gray mode: chroma must have no effect.
    queue_setting(ADDR_FORMAT, yrp_pkg::DATA_W'(yrp_pkg::FMT_RGBX));
    queue_setting(ADDR_GRAY, 32'd1);
    queue_pixel(8'd255, 8'd0,   8'd255, 1'b0);
    queue_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    queue_pixel(8'd16,  8'd77,  8'd99,  1'b0);
    queue_pixel(8'd235, 8'd200, 8'd10,  1'b0);

    // Random part: ten phases, every format code in both color and gray
    // mode, with junk in the unused data bits on odd phases. Two phases in
    // the middle run back to back with no gaps.
    for (int p = 0; p < 10; p++) begin
      fmt    = 2'(p % 4);
      gray   = ((p / 4) % 2) == 1;
      steady = (p == 5) || (p == 6);
      if (p % 2 == 1) begin
        queue_setting(ADDR_FORMAT, ($urandom & ~32'h3) | yrp_pkg::DATA_W'(fmt));
        queue_setting(ADDR_GRAY, ($urandom & ~32'h1) | yrp_pkg::DATA_W'(gray));
      end else begin
        queue_setting(ADDR_FORMAT, yrp_pkg::DATA_W'(fmt));
        queue_setting(ADDR_GRAY, yrp_pkg::DATA_W'(gray));
      end
      for (int k = 0; k < 110; k++) begin
        queue_pixel(pick_sample(), pick_sample(), pick_sample(), steady);
      end
    end

    // Release reset at a falling edge, away from the rising edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wait for every request to be taken, then for the results to drain.
    while (pend_q.size() != 0 || drv_state != DRV_STREAM || start) begin
      @(posedge clk);
    end
    n = 0;
    while (rgb_expect_q.size() != 0 && n < DRAIN_CYCLES) begin
      @(posedge clk);
      n++;
    end
    repeat (6) @(posedge clk);
    if (rgb_expect_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected pixels never came out", rgb_expect_q.size()));
    end

    $display("Checked %0d pixels: %0d as RGB565, %0d as RGB888, %0d padded, %0d in gray mode",
             pixels_checked, cnt_565, cnt_888, cnt_pad, cnt_gray);
    $display("Register writes with read-back: %0d, mismatches: %0d",
             reg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** ycbcr_to_rgb_pixel_packer: PASSED **");
    end else begin
      $display("** ycbcr_to_rgb_pixel_packer: FAILED **");
    end
    $finish;
  end

  // Watchdog: ends the run if stimulus or results stall.
  initial begin
    #500_000;
    $display("Timeout: stimulus or results stalled");
    $display("** ycbcr_to_rgb_pixel_packer: FAILED **");
    $finish;
  end

endmodule
